### rtl/tmpx_pkg.sv
// ----------------------------------------------------------------------------
// tmpx_pkg
// Shared types and constants for the TM M_PDU packet extractor.
// ----------------------------------------------------------------------------
`default_nettype none

package tmpx_pkg;

  localparam int unsigned PtrW   = 11;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned HcntW  = 3;
  localparam int unsigned LeftW  = 17;

  // Special first header pointer codes
  localparam logic [PtrW-1:0] PTR_IDLE = 11'd2046;
  localparam logic [PtrW-1:0] PTR_NONE = 11'd2047;
  localparam logic [PtrW-1:0] POS_MAX  = 11'd2047;

  localparam logic [HcntW-1:0] HDR_LEN     = 3'd6;
  localparam logic [HcntW-1:0] HDR_LEN_MSB = 3'd5;

  localparam logic [PtrW-1:0] ZONE_SIZE_RST = 11'd884;

  // One accepted input item
  typedef struct packed {
    logic             frame_start;
    logic [PtrW-1:0]  header_pointer;
    logic [ByteW-1:0] zone_byte;
  } in_item_t;

  // One result item
  typedef struct packed {
    logic [ByteW-1:0] packet_byte;
    logic             packet_start;
    logic             packet_end;
    logic             packet_cut;
  } out_item_t;

  // Frame context of the byte being processed
  typedef struct packed {
    logic [PtrW-1:0] pos;     // index of byte in zone
    logic [PtrW-1:0] fp;      // first header pointer of frame
    logic            fp_ok;   // pointer names a header in this frame
    logic            active;  // frame not skipped and byte inside zone
  } frame_ctx_t;

endpackage

`default_nettype wire

### rtl/tm_mpdu_packet_extractor.sv
// A result passes through the input register and then the output register.
// Throughput: one zone byte per cycle unless a held result waits on out_tready.
// Input and output registers hold one item each; the frame/packet logic is single-pass.
// Bytes that give no result leave the pipeline without an output cycle.
// Reset (rst_n low at a clock edge) empties both registers, closes any packet,
// ignores bytes until the next frame start and sets zone_size to 884.
// ----------------------------------------------------------------------------
// tm_mpdu_packet_extractor
// Extracts space packets from the packet zone of TM frames, byte by byte.
// ----------------------------------------------------------------------------
`default_nettype none

module tm_mpdu_packet_extractor (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  // input stream
  input  wire logic                       in_tvalid,
  output logic                            in_tready,
  input  wire logic [23:0]                in_tdata,  // header_pointer[10:0], zone_byte[18:11]
  input  wire logic [0:0]                 in_tuser,  // frame_start[0]
  // result stream
  output logic                            out_tvalid,
  input  wire logic                       out_tready,
  output logic [7:0]                      out_tdata, // packet_byte[7:0]
  output logic                            out_tlast, // packet_end
  output logic [1:0]                      out_tuser, // packet_start[0], packet_cut[1]
  // zone size register
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [tmpx_pkg::PtrW-1:0]  cfg_data
);
  import tmpx_pkg::*;

  logic            in_v_r;
  in_item_t        in_item_r;
  logic [PtrW-1:0] zone_size_r;
  logic            out_v_r;
  out_item_t       out_item_r;

  logic            step;
  logic            res_valid;
  out_item_t       res;
  frame_ctx_t      ctx;

  // Pipeline advance
  assign step      = in_v_r && (!out_v_r || out_tready);
  assign in_tready = !in_v_r || step;
  assign cfg_ready = 1'b1;

  // Zone size register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zone_size_r <= ZONE_SIZE_RST;
    end else if (cfg_valid) begin
      zone_size_r <= cfg_data;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_item_r.frame_start    <= in_tuser[0];
      in_item_r.header_pointer <= in_tdata[10:0];
      in_item_r.zone_byte      <= in_tdata[18:11];
    end
  end

  tmpx_frame_track u_frame (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .item      (in_item_r),
    .zone_size (zone_size_r),
    .ctx       (ctx)
  );

  tmpx_packet_track u_packet (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .ctx       (ctx),
    .zone_byte (in_item_r.zone_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (step) begin
      out_v_r <= res_valid;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res_valid) begin
      out_item_r <= res;
    end
  end

  assign out_tvalid   = out_v_r;
  assign out_tdata    = out_item_r.packet_byte;
  assign out_tlast    = out_item_r.packet_end;
  assign out_tuser[0] = out_item_r.packet_start;
  assign out_tuser[1] = out_item_r.packet_cut;

  // A stalled input register means the output side is blocking
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (in_v_r && out_v_r && !out_tready)) else $error("bad stall");

  // Cut marks only appear on a packet boundary byte
  a_cut_edge: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_item_r.packet_cut) |-> (out_item_r.packet_start || out_item_r.packet_end))
    else $error("cut on mid-packet byte");

  // A held result is not overwritten while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !out_tready) |=> (out_v_r && $stable(out_item_r)))
    else $error("result lost under stall");

endmodule

`default_nettype wire

### rtl/tmpx_frame_track.sv
// ----------------------------------------------------------------------------
// tmpx_frame_track
// Tracks zone position, first header pointer and skip flag of the frame.
// ----------------------------------------------------------------------------
`default_nettype none

module tmpx_frame_track (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     step,
  input  wire tmpx_pkg::in_item_t       item,
  input  wire logic [tmpx_pkg::PtrW-1:0] zone_size,
  output tmpx_pkg::frame_ctx_t          ctx
);
  import tmpx_pkg::*;

  logic [PtrW-1:0] pos_r, pos_nxt;
  logic [PtrW-1:0] fp_r, fp_nxt;
  logic            skip_r, skip_nxt;

  // Position and pointer for the byte in the input register
  always_comb begin
    if (item.frame_start) begin
      pos_nxt  = '0;
      fp_nxt   = item.header_pointer;
      skip_nxt = (item.header_pointer == PTR_IDLE) ||
                 ((item.header_pointer != PTR_NONE) && (item.header_pointer >= zone_size));
    end else begin
      pos_nxt  = (pos_r != POS_MAX) ? pos_r + 1'b1 : pos_r;
      fp_nxt   = fp_r;
      skip_nxt = skip_r;
    end
  end

  assign ctx.pos    = pos_nxt;
  assign ctx.fp     = fp_nxt;
  assign ctx.fp_ok  = (fp_nxt != PTR_NONE);
  assign ctx.active = !skip_nxt && (pos_nxt < zone_size);

  // Frame state, updated once per processed item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      fp_r   <= PTR_NONE;
      skip_r <= 1'b1;
    end else if (step) begin
      pos_r  <= pos_nxt;
      fp_r   <= fp_nxt;
      skip_r <= skip_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/tmpx_packet_track.sv
// ----------------------------------------------------------------------------
// tmpx_packet_track
// Follows packet headers and lengths, marks start, end and cut bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module tmpx_packet_track (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       step,
  input  wire tmpx_pkg::frame_ctx_t       ctx,
  input  wire logic [tmpx_pkg::ByteW-1:0] zone_byte,
  output logic                            res_valid,
  output tmpx_pkg::out_item_t             res
);
  import tmpx_pkg::*;

  logic             in_pkt_r, in_pkt_nxt;
  logic [HcntW-1:0] hcnt_r, hcnt_nxt;
  logic [ByteW-1:0] len_hi_r, len_hi_nxt;
  logic [LeftW-1:0] left_r, left_nxt;

  logic             hdr_here, start, brk_next, is_end, is_cut, open;
  logic [HcntW-1:0] hcnt_s;
  logic [LeftW-1:0] left_s;
  logic [PtrW:0]    pos_inc;

  // Packet step for one zone byte
  always_comb begin
    pos_inc  = {1'b0, ctx.pos} + 1'b1;
    hdr_here = ctx.fp_ok && (ctx.pos == ctx.fp);
    start    = hdr_here || (!in_pkt_r && ctx.fp_ok && (ctx.pos > ctx.fp));
    brk_next = ctx.fp_ok && (pos_inc == {1'b0, ctx.fp});
    open     = start || in_pkt_r;
    hcnt_s   = start ? '0 : hcnt_r;
    left_s   = start ? '0 : left_r;

    is_end     = 1'b0;
    is_cut     = hdr_here && in_pkt_r;
    hcnt_nxt   = hcnt_s;
    left_nxt   = left_s;
    len_hi_nxt = len_hi_r;

    if (hcnt_s < HDR_LEN) begin
      hcnt_nxt = hcnt_s + 1'b1;
      if (hcnt_nxt == HDR_LEN_MSB) begin
        len_hi_nxt = zone_byte;
      end else if (hcnt_nxt == HDR_LEN) begin
        left_nxt = {1'b0, len_hi_r, zone_byte} + 1'b1;
      end
    end else begin
      left_nxt = (left_s != '0) ? left_s - 1'b1 : left_s;
      is_end   = (left_nxt == '0);
    end

    // next byte is the pointed header: close here
    if (!is_end && brk_next) begin
      is_end = 1'b1;
      is_cut = 1'b1;
    end

    in_pkt_nxt = 1'b1;
    if (is_end) begin
      in_pkt_nxt = 1'b0;
      hcnt_nxt   = '0;
      left_nxt   = '0;
    end

    res_valid        = ctx.active && open;
    res.packet_byte  = zone_byte;
    res.packet_start = start;
    res.packet_end   = is_end;
    res.packet_cut   = is_cut;
  end

  // Packet state, held when the byte gives no result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_pkt_r <= 1'b0;
      hcnt_r   <= '0;
      len_hi_r <= '0;
      left_r   <= '0;
    end else if (step && res_valid) begin
      in_pkt_r <= in_pkt_nxt;
      hcnt_r   <= hcnt_nxt;
      len_hi_r <= len_hi_nxt;
      left_r   <= left_nxt;
    end
  end

  // Header count never runs past the primary header
  a_hcnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    hcnt_r <= HDR_LEN) else $error("header count out of range");

  // Closed packet carries no header progress or length
  a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !in_pkt_r |-> (hcnt_r == '0 && left_r == '0)) else $error("stale packet state");

  // Length is only loaded once the header is complete
  a_left_hdr: assert property (@(posedge clk) disable iff (!rst_n)
    (left_r != '0) |-> (hcnt_r == HDR_LEN)) else $error("length before header end");

endmodule

`default_nettype wire
